// ----- rtl/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the single-source shortest paths unit.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned IDX_W  = 4;
  localparam int unsigned EDGE_W = 16;
  localparam int unsigned DIST_W = 20;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = 5;
  localparam logic [CFG_AW-1:0] CFG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_SOURCE_VERTEX = 1'b1;
  localparam logic [CFG_DW-1:0] VERTEX_COUNT_RST  = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_RELAX,
    ST_EMIT
  } ssp_state_e;

endpackage

// ----- rtl/ssp_weight_mem.sv -----
// ----------------------------------------------------------------------------
// ssp_weight_mem
// Adjacency matrix store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ssp_weight_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/single_source_shortest_paths_unit.sv -----
// ----------------------------------------------------------------------------
// single_source_shortest_paths_unit
// Dijkstra shortest distances over a loaded weighted adjacency matrix.
// ----------------------------------------------------------------------------
// Matrix entries are taken one per cycle while the unit is idle and written
// to the weight memory; a zero weight means no edge. The entry flagged last
// starts a run over the n vertices in use, n being vertex_count clamped to
// 1..MAX_VERTICES: each round scans the distance memory for the closest
// unvisited vertex and then relaxes its row, and a final scan finds no
// vertex left. Results follow, one per vertex in order, each one issued
// only when the output register is free or being taken. The distance memory
// has a single read port. Input is held off from the last entry until the
// final result is in the output register.
module single_source_shortest_paths_unit #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ssp_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [ssp_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ssp_pkg::IDX_W-1:0]   from_vertex_i,
  input  logic [ssp_pkg::IDX_W-1:0]   to_vertex_i,
  input  logic [ssp_pkg::EDGE_W-1:0]  edge_weight_i,
  input  logic                        last_entry_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ssp_pkg::IDX_W-1:0]   vertex_o,
  output logic [ssp_pkg::DIST_W-1:0]  distance_o,
  output logic                        reachable_o,
  output logic                        last_result_o
);

  import ssp_pkg::*;

  localparam int unsigned DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SW    = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

  ssp_state_e state_q, state_d;

  logic [CFG_DW-1:0] vertex_count_q;
  logic [IDX_W-1:0]  source_q;

  logic [CW-1:0]           n_q, n_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [MAX_VERTICES-1:0] known_q, known_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic                    pick_valid_q, pick_valid_d;
  logic [VW-1:0]           pick_q, pick_d;
  logic [DIST_W-1:0]       pick_dist_q, pick_dist_d;
  logic                    s1_valid_q, s1_valid_d;
  logic [VW-1:0]           s1_v_q, s1_v_d;

  logic                    out_valid_q, out_valid_d;
  logic [IDX_W-1:0]        vertex_q, vertex_d;
  logic [DIST_W-1:0]       distance_q, distance_d;
  logic                    reachable_q, reachable_d;
  logic                    last_q, last_d;

  logic              in_fire;
  logic              issue;
  logic              cnt_done;
  logic              drained;
  logic              src_ok;
  logic              w_we;
  logic [AW-1:0]     w_waddr;
  logic [AW-1:0]     w_raddr;
  logic [WEIGHT_BITS-1:0] w_rdata;

  logic              dist_we;
  logic [VW-1:0]     dist_waddr;
  logic [DIST_W-1:0] dist_wdata;
  logic [VW-1:0]     dist_raddr;
  logic [DIST_W-1:0] dist_rdata_q;
  logic [DIST_W-1:0] dist_mem_q [MAX_VERTICES];

  logic [SW-1:0]     cand_sum;
  logic [DIST_W-1:0] cand;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cnt_done   = (cnt_q == n_q);
  assign drained    = cnt_done && !s1_valid_q;
  assign src_ok     = (int'(source_q) < int'(n_q));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RST;
      source_q       <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_VERTEX_COUNT) begin
        vertex_count_q <= cfg_data_i;
      end else if (cfg_addr_i == CFG_SOURCE_VERTEX) begin
        source_q <= IDX_W'(cfg_data_i);
      end
    end
  end

  // matrix loading
  assign w_we    = in_fire && (int'(from_vertex_i) < int'(MAX_VERTICES))
                           && (int'(to_vertex_i) < int'(MAX_VERTICES));
  assign w_waddr = AW'(int'(from_vertex_i) * int'(MAX_VERTICES) + int'(to_vertex_i));
  assign w_raddr = AW'(int'(pick_q) * int'(MAX_VERTICES) + int'(cnt_q[VW-1:0]));

  ssp_weight_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WEIGHT_BITS)
  ) u_weight_mem (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (WEIGHT_BITS'(edge_weight_i)),
    .re_i    (issue && (state_q == ST_RELAX)),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // distance memory
  assign dist_raddr = cnt_q[VW-1:0];

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem_q[dist_waddr] <= dist_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      dist_rdata_q <= dist_mem_q[dist_raddr];
    end
  end

  // relaxation candidate, saturated
  assign cand_sum = SW'(pick_dist_q) + SW'(w_rdata);
  assign cand     = (cand_sum > SW'(DIST_MAX)) ? DIST_MAX : DIST_W'(cand_sum);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && last_entry_i) state_d = ST_INIT;
      end
      ST_INIT: state_d = ST_SCAN;
      ST_SCAN: begin
        if (drained) state_d = pick_valid_q ? ST_RELAX : ST_EMIT;
      end
      ST_RELAX: begin
        if (drained) state_d = ST_SCAN;
      end
      ST_EMIT: begin
        if (drained) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    int vc;
    int nv;
    vc = int'(vertex_count_q);
    nv = (vc == 0) ? 1 : ((vc > int'(MAX_VERTICES)) ? int'(MAX_VERTICES) : vc);

    n_d          = n_q;
    cnt_d        = cnt_q;
    known_d      = known_q;
    visited_d    = visited_q;
    pick_valid_d = pick_valid_q;
    pick_d       = pick_q;
    pick_dist_d  = pick_dist_q;
    s1_valid_d   = 1'b0;
    s1_v_d       = s1_v_q;
    issue        = 1'b0;
    dist_we      = 1'b0;
    dist_waddr   = s1_v_q;
    dist_wdata   = cand;
    out_valid_d  = out_valid_q && !out_ready_i;
    vertex_d     = vertex_q;
    distance_d   = distance_q;
    reachable_d  = reachable_q;
    last_d       = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && last_entry_i) n_d = CW'(nv);
      end
      ST_INIT: begin
        known_d      = '0;
        visited_d    = '0;
        cnt_d        = '0;
        pick_valid_d = 1'b0;
        if (src_ok) begin
          known_d[VW'(source_q)] = 1'b1;
          dist_we    = 1'b1;
          dist_waddr = VW'(source_q);
          dist_wdata = '0;
        end
      end
      ST_SCAN: begin
        if (!cnt_done) begin
          issue      = 1'b1;
          cnt_d      = cnt_q + CW'(1);
          s1_valid_d = 1'b1;
          s1_v_d     = cnt_q[VW-1:0];
        end
        if (s1_valid_q && known_q[s1_v_q] && !visited_q[s1_v_q] &&
            (!pick_valid_q || dist_rdata_q < pick_dist_q)) begin
          pick_valid_d = 1'b1;
          pick_d       = s1_v_q;
          pick_dist_d  = dist_rdata_q;
        end
        if (drained) begin
          cnt_d = '0;
          if (pick_valid_q) visited_d[pick_q] = 1'b1;
        end
      end
      ST_RELAX: begin
        if (!cnt_done) begin
          issue      = 1'b1;
          cnt_d      = cnt_q + CW'(1);
          s1_valid_d = 1'b1;
          s1_v_d     = cnt_q[VW-1:0];
        end
        if (s1_valid_q && (w_rdata != '0) && !visited_q[s1_v_q] &&
            (!known_q[s1_v_q] || cand < dist_rdata_q)) begin
          dist_we          = 1'b1;
          known_d[s1_v_q]  = 1'b1;
        end
        if (drained) begin
          cnt_d        = '0;
          pick_valid_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (!cnt_done && !s1_valid_q && (!out_valid_q || out_ready_i)) begin
          issue      = 1'b1;
          cnt_d      = cnt_q + CW'(1);
          s1_valid_d = 1'b1;
          s1_v_d     = cnt_q[VW-1:0];
        end
        if (s1_valid_q) begin
          out_valid_d = 1'b1;
          vertex_d    = IDX_W'(s1_v_q);
          distance_d  = known_q[s1_v_q] ? dist_rdata_q : '0;
          reachable_d = known_q[s1_v_q];
          last_d      = ((CW'(s1_v_q) + CW'(1)) == n_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      n_q          <= '0;
      cnt_q        <= '0;
      known_q      <= '0;
      visited_q    <= '0;
      pick_valid_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      cnt_q        <= cnt_d;
      known_q      <= known_d;
      visited_q    <= visited_d;
      pick_valid_q <= pick_valid_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q      <= pick_d;
    pick_dist_q <= pick_dist_d;
    s1_v_q      <= s1_v_d;
    vertex_q    <= vertex_d;
    distance_q  <= distance_d;
    reachable_q <= reachable_d;
    last_q      <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_o      = vertex_q;
  assign distance_o    = distance_q;
  assign reachable_o   = reachable_q;
  assign last_result_o = last_q;

endmodule
